// ===== rtl/dwsr_pkg.sv =====
// Package for the dual wheel speed regulator.
// Field widths, register codes and reset values, controller states and datapath command types.
// No dependencies.
package dwsr_pkg;

  localparam int COUNT_W     = 32;
  localparam int ELAPSED_W   = 16;
  localparam int TARGET_W    = 14;
  localparam int GAIN_W      = 12;
  localparam int DPP_W       = 24;
  localparam int TOL_W       = 13;
  localparam int DRIVE_W     = 14;
  localparam int SPEED_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int QUOT_W      = 17;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int GAIN_SHIFT  = 8;
  localparam int DPP_SCALE   = 32;

  localparam logic [TARGET_W-1:0] TARGET_LEFT_RST  = 14'd1229;
  localparam logic [TARGET_W-1:0] TARGET_RIGHT_RST = 14'd1229;
  localparam logic [GAIN_W-1:0]   LOOP_GAIN_RST    = 12'd307;
  localparam logic [DPP_W-1:0]    DPP_RST          = 24'd632476;
  localparam logic [TOL_W-1:0]    TOL_RST          = 13'd205;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_LEFT  = 3'd0,
    CFG_TARGET_RIGHT = 3'd1,
    CFG_LOOP_GAIN    = 3'd2,
    CFG_DPP          = 3'd3,
    CFG_MATCH_TOL    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_left;
    logic [TARGET_W-1:0] target_right;
    logic [GAIN_W-1:0]   loop_gain;
    logic [DPP_W-1:0]    distance_per_pulse;
    logic [TOL_W-1:0]    match_tolerance;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_DELTA,
    DP_MUL,
    DP_SCALE,
    DP_DIV_STEP,
    DP_SAT,
    DP_GMUL,
    DP_DRIVE,
    DP_EQ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   wheel;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_SAT,
    ST_GMUL,
    ST_DRIVE,
    ST_EQ
  } state_t;

endpackage

// ===== rtl/dwsr_ifs.sv =====
// Valid/ready channel interfaces for the dual wheel speed regulator.
// Depends on dwsr_pkg for field widths.
interface dwsr_in_if import dwsr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COUNT_W-1:0]   left_count;
  logic signed [COUNT_W-1:0]   right_count;
  logic        [ELAPSED_W-1:0] elapsed_ms;

  modport source(output valid, left_count, right_count, elapsed_ms, input ready);
  modport sink(input valid, left_count, right_count, elapsed_ms, output ready);
endinterface

interface dwsr_out_if import dwsr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;

  modport source(output valid, left_drive, right_drive, left_speed, right_speed, input ready);
  modport sink(input valid, left_drive, right_drive, left_speed, right_speed, output ready);
endinterface

// ===== rtl/dwsr_cfg_regs.sv =====
// Configuration register file: targets, gain, distance per pulse, match tolerance.
// Depends on dwsr_pkg.
module dwsr_cfg_regs import dwsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TARGET_LEFT:  cfg_nxt.target_left        = cfg_wdata[TARGET_W-1:0];
        CFG_TARGET_RIGHT: cfg_nxt.target_right       = cfg_wdata[TARGET_W-1:0];
        CFG_LOOP_GAIN:    cfg_nxt.loop_gain          = cfg_wdata[GAIN_W-1:0];
        CFG_DPP:          cfg_nxt.distance_per_pulse = cfg_wdata[DPP_W-1:0];
        CFG_MATCH_TOL:    cfg_nxt.match_tolerance    = cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_left        <= TARGET_LEFT_RST;
      cfg_r.target_right       <= TARGET_RIGHT_RST;
      cfg_r.loop_gain          <= LOOP_GAIN_RST;
      cfg_r.distance_per_pulse <= DPP_RST;
      cfg_r.match_tolerance    <= TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/dwsr_ctrl.sv =====
// Controller: sequences both wheels through delta, multiply, scale, serial divide,
// saturate, gain and clamp, then equalizes and loads the output register. Depends on dwsr_pkg.
module dwsr_ctrl import dwsr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic                 wheel_r, wheel_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wheel_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wheel_nxt     = wheel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = DP_NOP;
    cmd.wheel     = wheel_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_CAPTURE;
          wheel_nxt = 1'b0;
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.op    = DP_DELTA;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op    = DP_MUL;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op    = DP_SCALE;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.op    = DP_SAT;
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.op    = DP_GMUL;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd.op = DP_DRIVE;
        if (!wheel_r) begin
          wheel_nxt = 1'b1;
          state_nxt = ST_DELTA;
        end else begin
          state_nxt = ST_EQ;
        end
      end
      ST_EQ: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_EQ;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= DIV_CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

  a_eq_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EQ |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented after equalize");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && !in_valid |=> state_r == ST_IDLE)
    else $error("left idle without an accepted item");

  a_second_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EQ |-> wheel_r)
    else $error("equalize reached before the right wheel");

endmodule

// ===== rtl/dwsr_datapath.sv =====
// Datapath: previous counts, shared multiplier, restoring divider, gain stage,
// drive clamp, equalization and output payload registers. Depends on dwsr_pkg.
module dwsr_datapath import dwsr_pkg::*; #(
  parameter int COUNT_BITS    = 32,
  parameter int FRACTION_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  input  cfg_t                        cfg,
  input  logic signed [COUNT_W-1:0]   in_left_count,
  input  logic signed [COUNT_W-1:0]   in_right_count,
  input  logic        [ELAPSED_W-1:0] in_elapsed_ms,
  output logic signed [DRIVE_W-1:0]   out_left_drive,
  output logic signed [DRIVE_W-1:0]   out_right_drive,
  output logic signed [SPEED_W-1:0]   out_left_speed,
  output logic signed [SPEED_W-1:0]   out_right_speed
);

  localparam int PROD_W  = COUNT_BITS + DPP_W;
  localparam int SC_W    = PROD_W + 10;
  localparam int SHIFT   = DPP_SCALE - FRACTION_BITS;
  localparam int NUM_W   = SC_W - SHIFT;
  localparam int TOP_W   = NUM_W - QUOT_W;
  localparam int CMP_W   = (TOP_W > ELAPSED_W) ? TOP_W : ELAPSED_W;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int GP_W    = ERR_W + GAIN_W + 1;
  localparam int TDIFF_W = TARGET_W + 1;
  localparam logic signed [GP_W-1:0] DRV_ONE = GP_W'(1 << FRACTION_BITS);
  localparam logic signed [GP_W-1:0] DRV_NEG = -DRV_ONE;
  localparam logic [QUOT_W-1:0] POS_MAX = QUOT_W'(32767);
  localparam logic [QUOT_W-1:0] NEG_MAX = QUOT_W'(32768);

  logic [COUNT_BITS-1:0]     left_count_r, right_count_r;
  logic [COUNT_BITS-1:0]     prev_left_r, prev_left_nxt, prev_right_r, prev_right_nxt;
  logic [ELAPSED_W-1:0]      ms_r;
  logic                      neg_r;
  logic [COUNT_BITS-1:0]     mag_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      ovf_r;
  logic [ELAPSED_W-1:0]      rem_r;
  logic [QUOT_W-1:0]         quot_r;
  logic signed [SPEED_W-1:0] speed_l_r, speed_r_r;
  logic signed [GP_W-1:0]    gprod_r;
  logic signed [DRIVE_W-1:0] drive_l_r, drive_r_r;
  logic signed [DRIVE_W-1:0] out_ld_r, out_rd_r;
  logic signed [SPEED_W-1:0] out_ls_r, out_rs_r;

  logic [COUNT_BITS-1:0]     cur_cnt, cur_prev, diff;
  logic [SC_W-1:0]           scaled;
  logic [NUM_W-1:0]          num;
  logic [TOP_W-1:0]          num_top;
  logic                      ovf_nxt;
  logic [QUOT_W-1:0]         trial;
  logic                      qbit;
  logic [QUOT_W-1:0]         mag_q;
  logic signed [SPEED_W-1:0] speed_sat;
  logic signed [TARGET_W-1:0] tgt, tgt_l, tgt_r;
  logic signed [SPEED_W-1:0] spd;
  logic signed [ERR_W-1:0]   err;
  logic signed [GP_W-1:0]    corr, drv;
  logic signed [DRIVE_W-1:0] drv_clamped;
  logic signed [TDIFF_W-1:0] tdiff;
  logic [TDIFF_W-1:0]        tdiff_abs;
  logic                      match;

  always_comb begin
    tgt_l    = $signed(cfg.target_left);
    tgt_r    = $signed(cfg.target_right);
    tgt      = cmd.wheel ? tgt_r : tgt_l;
    spd      = cmd.wheel ? speed_r_r : speed_l_r;
    cur_cnt  = cmd.wheel ? right_count_r : left_count_r;
    cur_prev = cmd.wheel ? prev_right_r : prev_left_r;
    diff     = cur_cnt - cur_prev;

    scaled  = (SC_W'(prod_r) << 10) - (SC_W'(prod_r) << 4) - (SC_W'(prod_r) << 3);
    num     = scaled[SC_W-1:SHIFT];
    num_top = num[NUM_W-1:QUOT_W];
    ovf_nxt = CMP_W'(num_top) >= CMP_W'(ms_r);

    trial = {rem_r, quot_r[QUOT_W-1]};
    qbit  = trial >= QUOT_W'(ms_r);

    mag_q = quot_r;
    if (neg_r) begin
      speed_sat = (ovf_r || mag_q > NEG_MAX) ? SPEED_W'(NEG_MAX)
                                             : SPEED_W'(QUOT_W'(0) - mag_q);
    end else begin
      speed_sat = (ovf_r || mag_q > POS_MAX) ? SPEED_W'(POS_MAX) : SPEED_W'(mag_q);
    end

    err  = ERR_W'(tgt) - ERR_W'(spd);
    corr = gprod_r >>> GAIN_SHIFT;
    drv  = GP_W'(tgt) + corr;
    if (drv > DRV_ONE) begin
      drv_clamped = DRIVE_W'(DRV_ONE);
    end else if (drv < DRV_NEG) begin
      drv_clamped = DRIVE_W'(DRV_NEG);
    end else begin
      drv_clamped = DRIVE_W'(drv);
    end

    tdiff     = TDIFF_W'(tgt_l) - TDIFF_W'(tgt_r);
    tdiff_abs = tdiff[TDIFF_W-1] ? TDIFF_W'(-tdiff) : TDIFF_W'(tdiff);
    match     = tdiff_abs < TDIFF_W'(cfg.match_tolerance);

    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    if (cmd.op == DP_DELTA) begin
      if (cmd.wheel) begin
        prev_right_nxt = cur_cnt;
      end else begin
        prev_left_nxt = cur_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else begin
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        left_count_r  <= in_left_count[COUNT_BITS-1:0];
        right_count_r <= in_right_count[COUNT_BITS-1:0];
        ms_r          <= (in_elapsed_ms == '0) ? ELAPSED_W'(1) : in_elapsed_ms;
      end
      DP_DELTA: begin
        neg_r <= diff[COUNT_BITS-1];
        mag_r <= diff[COUNT_BITS-1] ? (COUNT_BITS'(0) - diff) : diff;
      end
      DP_MUL: begin
        prod_r <= PROD_W'(mag_r) * PROD_W'(cfg.distance_per_pulse);
      end
      DP_SCALE: begin
        ovf_r  <= ovf_nxt;
        rem_r  <= ovf_nxt ? '0 : ELAPSED_W'(num_top);
        quot_r <= num[QUOT_W-1:0];
      end
      DP_DIV_STEP: begin
        rem_r  <= qbit ? ELAPSED_W'(trial - QUOT_W'(ms_r)) : trial[ELAPSED_W-1:0];
        quot_r <= {quot_r[QUOT_W-2:0], qbit};
      end
      DP_SAT: begin
        if (cmd.wheel) begin
          speed_r_r <= speed_sat;
        end else begin
          speed_l_r <= speed_sat;
        end
      end
      DP_GMUL: begin
        gprod_r <= GP_W'(err) * GP_W'($signed({1'b0, cfg.loop_gain}));
      end
      DP_DRIVE: begin
        if (cmd.wheel) begin
          drive_r_r <= drv_clamped;
        end else begin
          drive_l_r <= drv_clamped;
        end
      end
      DP_EQ: begin
        out_ls_r <= speed_l_r;
        out_rs_r <= speed_r_r;
        out_ld_r <= (match && speed_l_r > speed_r_r) ? drive_r_r : drive_l_r;
        out_rd_r <= (match && speed_r_r > speed_l_r) ? drive_l_r : drive_r_r;
      end
      default: ;
    endcase
  end

  assign out_left_drive  = out_ld_r;
  assign out_right_drive = out_rd_r;
  assign out_left_speed  = out_ls_r;
  assign out_right_speed = out_rs_r;

endmodule

// ===== rtl/dual_wheel_speed_regulator_core.sv =====
// Top level of the dual wheel speed regulator: config registers, controller, datapath.
// Depends on dwsr_pkg, dwsr_ifs, dwsr_cfg_regs, dwsr_ctrl and dwsr_datapath.
//
//   channel  | dir | fields                                           | handshake
//   in_ch    | in  | left_count, right_count, elapsed_ms              | valid/ready
//   out_ch   | out | left_drive, right_drive, left_speed, right_speed | valid/ready
//   cfg_*    | in  | cfg_index, cfg_wdata                             | cfg_we
//
// From acceptance to the result register, each wheel in turn runs through the
// serial restoring divider among its other steps, then equalize loads the result.
// Both wheels share the multiplier and divider, so wheels run one after the other;
// a new item is accepted only in the idle state, once the previous item is loaded.
// Synchronous active-low reset clears previous counts and reloads register defaults.
// in_ch.ready is high only between items; a stalled result holds and blocks only
// the final load of the next item.
module dual_wheel_speed_regulator_core import dwsr_pkg::*; #(
  parameter int COUNT_BITS    = 32,
  parameter int FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  dwsr_in_if.sink                in_ch,
  dwsr_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  dwsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dwsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dwsr_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_left_count   (in_ch.left_count),
    .in_right_count  (in_ch.right_count),
    .in_elapsed_ms   (in_ch.elapsed_ms),
    .out_left_drive  (out_ch.left_drive),
    .out_right_drive (out_ch.right_drive),
    .out_left_speed  (out_ch.left_speed),
    .out_right_speed (out_ch.right_speed)
  );

endmodule

// ===== test/dual_wheel_speed_regulator_core_tb.sv =====
// Self-checking testbench for dual_wheel_speed_regulator_core: sample ticks go in, drives and
// measured wheel speeds come out, each result checked against a regulator model kept in the bench.
// Depends on dwsr_pkg, the dwsr_ifs channel interfaces and the core RTL.
`timescale 1ns / 100ps

module dual_wheel_speed_regulator_core_tb;
  import dwsr_pkg::*;

  localparam int     FRAC_BITS   = 12;
  localparam longint DRIVE_ONE   = 64'sd1 << FRAC_BITS;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     SETTLE      = 60;
  localparam int     HOLD_CYCLES = 600;
  localparam int     MAX_REPORTS = 40;
  localparam int     PHASES      = 10;
  localparam int     PHASE_TICKS = 125;

  typedef struct packed {
    logic [COUNT_W-1:0]   left;
    logic [COUNT_W-1:0]   right;
    logic [ELAPSED_W-1:0] ms;
  } tick_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } regulation_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  tick_t                  in_tick   = '0;
  logic                   out_ready = 1'b0;

  dwsr_in_if  in_ch();
  dwsr_out_if out_ch();

  assign in_ch.valid       = in_valid;
  assign in_ch.left_count  = in_tick.left;
  assign in_ch.right_count = in_tick.right;
  assign in_ch.elapsed_ms  = in_tick.ms;
  assign out_ch.ready      = out_ready;

  dual_wheel_speed_regulator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic signed [TARGET_W-1:0] m_target_left  = TARGET_LEFT_RST;
  logic signed [TARGET_W-1:0] m_target_right = TARGET_RIGHT_RST;
  logic [GAIN_W-1:0]          m_gain         = LOOP_GAIN_RST;
  logic [DPP_W-1:0]           m_dpp          = DPP_RST;
  logic [TOL_W-1:0]           m_tol          = TOL_RST;
  logic [COUNT_W-1:0]         m_prev_left    = '0;
  logic [COUNT_W-1:0]         m_prev_right   = '0;

  tick_t       tick_queue[$];
  regulation_t due_regulations[$];

  logic               sending       = 1'b0;
  int unsigned        send_wait     = 0;
  int unsigned        recv_wait     = 0;
  int unsigned        send_gap_max  = 3;
  int unsigned        recv_gap_max  = 3;
  int unsigned        ticks_offered = 0;
  int unsigned        ticks_taken   = 0;
  int unsigned        results_taken = 0;
  int unsigned        results_seen  = 0;
  int unsigned        hold_requests = 0;
  int unsigned        holds_served  = 0;
  int unsigned        hold_left     = 0;
  int unsigned        cycle_count   = 0;
  int unsigned        error_count   = 0;
  logic [COUNT_W-1:0] gen_left      = '0;
  logic [COUNT_W-1:0] gen_right     = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [SPEED_W-1:0] wheel_speed_of(
      input logic [COUNT_W-1:0] count, input logic [COUNT_W-1:0] prev,
      input logic [ELAPSED_W-1:0] ms);
    logic signed [COUNT_W-1:0] delta;
    longint unsigned mag, prod, den, quo, rem, rate;
    longint speed;
    delta = count - prev;
    if (delta < 0) mag = -longint'(delta);
    else mag = longint'(delta);
    prod = mag * 64'(m_dpp);
    den = 64'(ms);
    if (den == 0) den = 1;
    den = den << (DPP_SCALE - FRAC_BITS);
    quo = prod / den;
    rem = prod % den;
    rate = (quo >= 33) ? 40000 : quo * 1000 + rem * 1000 / den;
    if (delta < 0) speed = (rate > 32768) ? -32768 : -longint'(rate);
    else speed = (rate > 32767) ? 32767 : longint'(rate);
    return speed[SPEED_W-1:0];
  endfunction

  function automatic longint drive_of(input longint target, input longint speed);
    longint d;
    d = target + ((longint'(m_gain) * (target - speed)) >>> GAIN_SHIFT);
    if (d > DRIVE_ONE) d = DRIVE_ONE;
    if (d < -DRIVE_ONE) d = -DRIVE_ONE;
    return d;
  endfunction

  function automatic regulation_t regulate_tick(input tick_t t);
    regulation_t r;
    longint sl, sr, dl, dr, tdiff;
    sl = longint'(wheel_speed_of(t.left, m_prev_left, t.ms));
    sr = longint'(wheel_speed_of(t.right, m_prev_right, t.ms));
    dl = drive_of(longint'(m_target_left), sl);
    dr = drive_of(longint'(m_target_right), sr);
    tdiff = longint'(m_target_left) - longint'(m_target_right);
    if (tdiff < 0) tdiff = -tdiff;
    if (tdiff < longint'(m_tol)) begin
      if (sl > sr) dl = dr;
      else if (sr > sl) dr = dl;
    end
    r.left_drive  = dl[DRIVE_W-1:0];
    r.right_drive = dr[DRIVE_W-1:0];
    r.left_speed  = sl[SPEED_W-1:0];
    r.right_speed = sr[SPEED_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_TARGET_LEFT:  m_target_left  = data[TARGET_W-1:0];
      CFG_TARGET_RIGHT: m_target_right = data[TARGET_W-1:0];
      CFG_LOOP_GAIN:    m_gain         = data[GAIN_W-1:0];
      CFG_DPP:          m_dpp          = data[DPP_W-1:0];
      CFG_MATCH_TOL:    m_tol          = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (tick_queue.size() != 0 || ticks_taken != ticks_offered
           || due_regulations.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_ticks
    if (rst_n) begin
      if (sending && ticks_taken == ticks_offered) begin
        sending   = 1'b0;
        send_wait = $urandom_range(send_gap_max, 0);
      end
      if (!sending) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (tick_queue.size() > 0) begin
          in_tick <= tick_queue.pop_front();
          ticks_offered++;
          sending = 1'b1;
        end
      end
      in_valid <= sending;
    end
  end

  always @(negedge clk) begin : accept_results
    if (results_taken != results_seen) begin
      results_seen = results_taken;
      recv_wait    = $urandom_range(recv_gap_max, 0);
    end else if (recv_wait > 0) begin
      recv_wait--;
    end
    out_ready <= rst_n && recv_wait == 0 && hold_left == 0;
  end

  always @(posedge clk) begin : long_hold
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin : watch_channels
    regulation_t got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dual_wheel_speed_regulator_core_tb: FAIL");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_taken++;
        got.left_drive  = out_ch.left_drive;
        got.right_drive = out_ch.right_drive;
        got.left_speed  = out_ch.left_speed;
        got.right_speed = out_ch.right_speed;
        if (due_regulations.size() == 0) begin
          report_mismatch("unrequested result, left_drive", longint'(got.left_drive), 0);
        end else begin
          want = due_regulations.pop_front();
          if (got.left_drive !== want.left_drive)
            report_mismatch("left_drive", longint'(got.left_drive),
                            longint'(want.left_drive));
          if (got.right_drive !== want.right_drive)
            report_mismatch("right_drive", longint'(got.right_drive),
                            longint'(want.right_drive));
          if (got.left_speed !== want.left_speed)
            report_mismatch("left_speed", longint'(got.left_speed),
                            longint'(want.left_speed));
          if (got.right_speed !== want.right_speed)
            report_mismatch("right_speed", longint'(got.right_speed),
                            longint'(want.right_speed));
        end
      end
      if (rst_n && in_ch.valid && in_ch.ready) begin
        due_regulations.push_back(regulate_tick(in_tick));
        m_prev_left  = in_tick.left;
        m_prev_right = in_tick.right;
        ticks_taken++;
      end
    end
  end

  initial begin : run_test
    int tl, tr, spread, kind;
    logic [CFG_DATA_W-1:0] w_tl, w_tr, w_gain, w_dpp, w_tol;
    logic [ELAPSED_W-1:0] ms;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    // reset settings: equal targets, so the faster wheel takes the slower one's drive
    tick_queue.push_back('{32'd0, 32'd0, 16'd50});
    tick_queue.push_back('{32'd300, 32'd250, 16'd50});
    tick_queue.push_back('{32'd500, 32'd550, 16'd50});
    tick_queue.push_back('{32'd700, 32'd750, 16'd50});
    tick_queue.push_back('{32'd600, 32'd650, 16'd50});
    tick_queue.push_back('{32'd400, 32'd700, 16'd50});
    tick_queue.push_back('{32'd510, 32'd800, 16'd50});
    tick_queue.push_back('{32'd511, 32'd799, 16'd1});
    tick_queue.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 16'd1});
    tick_queue.push_back('{32'd0, 32'd0, 16'd1});
    tick_queue.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 16'd1});
    tick_queue.push_back('{32'd0, 32'd0, 16'hFFFF});
    tick_queue.push_back('{32'd10, 32'hFFFF_FFF6, 16'd0});
    tick_queue.push_back('{32'd20, 32'hFFFF_FFEC, 16'hFFFF});
    tick_queue.push_back('{32'hFFFF_FFF0, 32'h0000_0010, 16'd40});
    tick_queue.push_back('{32'h0000_0010, 32'hFFFF_FFF0, 16'd40});
    tick_queue.push_back('{32'h0000_07E0, 32'hFFFF_F820, 16'd50});
    tick_queue.push_back('{32'h0000_1800, 32'hFFFF_E000, 16'd50});
    tick_queue.push_back('{32'h0000_186E, 32'hFFFF_E064, 16'd50});
    tick_queue.push_back('{32'h0000_186E, 32'hFFFF_E064, 16'd0});
    gen_left  = tick_queue[$].left;
    gen_right = tick_queue[$].right;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        w_tl = CFG_DATA_W'(DRIVE_ONE);
        w_tr = CFG_DATA_W'(DRIVE_ONE);
        w_gain = '1;
        w_dpp = '1;
        w_tol = CFG_DATA_W'(DRIVE_ONE);
      end else if (p == 1) begin
        w_tl = CFG_DATA_W'(-DRIVE_ONE);
        w_tr = CFG_DATA_W'(-DRIVE_ONE);
        w_gain = '0;
        w_dpp = '0;
        w_tol = '0;
      end else if (p == 2) begin
        w_tl = CFG_DATA_W'($urandom());
        w_tr = CFG_DATA_W'($urandom());
        w_gain = CFG_DATA_W'($urandom());
        w_dpp = CFG_DATA_W'($urandom());
        w_tol = CFG_DATA_W'($urandom());
      end else begin
        tl = int'($urandom_range(8192, 0)) - 4096;
        if ($urandom_range(1, 0)) begin
          tr = tl + int'($urandom_range(600, 0)) - 300;
          if (tr > 4096) tr = 4096;
          if (tr < -4096) tr = -4096;
        end else begin
          tr = int'($urandom_range(8192, 0)) - 4096;
        end
        w_tl = CFG_DATA_W'(tl);
        w_tr = CFG_DATA_W'(tr);
        w_gain = CFG_DATA_W'($urandom_range(4095, 0));
        if ($urandom_range(3, 0) == 0) w_dpp = CFG_DATA_W'($urandom_range(24'hFFFFFF, 0));
        else w_dpp = CFG_DATA_W'($urandom_range(1500000, 100000));
        w_tol = CFG_DATA_W'($urandom_range(4096, 0));
      end
      for (int i = int'(CFG_MATCH_TOL) + 1; i < (1 << CFG_INDEX_W); i++)
        write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom()));
      write_reg(CFG_TARGET_LEFT, w_tl);
      write_reg(CFG_TARGET_RIGHT, w_tr);
      write_reg(CFG_LOOP_GAIN, w_gain);
      write_reg(CFG_DPP, w_dpp);
      write_reg(CFG_MATCH_TOL, w_tol);
      send_gap_max = (p % 3 == 1) ? 0 : 5;
      recv_gap_max = (p % 4 == 2) ? 0 : 5;
      if (p == 3 || p == 7) hold_requests++;
      @(posedge clk);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        kind = $urandom_range(15, 0);
        ms = ELAPSED_W'($urandom_range(80, 20));
        if (kind <= 10) begin
          case ($urandom_range(2, 0))
            0: spread = 15;
            1: spread = 300;
            default: spread = 3000;
          endcase
          gen_left  += COUNT_W'(int'($urandom_range(2 * spread, 0)) - spread);
          gen_right += COUNT_W'(int'($urandom_range(2 * spread, 0)) - spread);
        end else if (kind <= 12) begin
          gen_left  = $urandom();
          gen_right = $urandom();
          ms = ELAPSED_W'($urandom());
        end else if (kind == 13) begin
          gen_left  += COUNT_W'(int'($urandom_range(40, 0)) - 20);
          gen_right += COUNT_W'(int'($urandom_range(40, 0)) - 20);
          case ($urandom_range(2, 0))
            0: ms = '0;
            1: ms = ELAPSED_W'(1);
            default: ms = '1;
          endcase
        end else if (kind == 14) begin
          ms = ELAPSED_W'($urandom());
        end else begin
          gen_left  += $urandom();
          gen_right -= $urandom_range(200000, 0);
          ms = ELAPSED_W'($urandom_range(100, 1));
        end
        tick_queue.push_back('{gen_left, gen_right, ms});
      end
    end

    @(negedge clk);
    wait_idle();
    if (error_count == 0) begin
      $display("dual_wheel_speed_regulator_core_tb: PASS");
    end else begin
      $display("dual_wheel_speed_regulator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
